// File: sv/rv32i_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// rv32i_execute_unit_defines
// Assertion macros shared by the execute unit.
// ----------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_UNIT_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define RVEX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rv32i_execute_unit: same-cycle check failed");

// Next-cycle implication, held off while in reset.
`define RVEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rv32i_execute_unit: next-cycle check failed");

`endif

// File: sv/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// Types and constants for the RV32I execute unit.
// ----------------------------------------------------------------------------
package rvex_pkg;

    // Predictor table size; assumed a power of two
    localparam int PREDICTOR_ENTRIES = 8;

    localparam int          XLEN           = 32;
    localparam int          ACT_W          = 6;
    localparam int          REG_W          = 6;
    localparam int          SLOT_W         = 3;
    localparam int          SHAMT_W        = 5;
    localparam logic [XLEN-1:0] PRED_SLOT_MASK = XLEN'(PREDICTOR_ENTRIES - 1);
    localparam logic [XLEN-1:0] PC_STEP        = XLEN'(4);
    localparam logic [XLEN-1:0] JALR_MASK      = 32'hFFFF_FFFE;
    localparam logic [REG_W-1:0] NO_DEST       = REG_W'(32);

    typedef enum logic [ACT_W-1:0] {
        A_ADD   = 6'd0,  A_SUB   = 6'd1,  A_XOR   = 6'd2,  A_OR    = 6'd3,
        A_AND   = 6'd4,  A_SLL   = 6'd5,  A_SRL   = 6'd6,  A_SRA   = 6'd7,
        A_SLT   = 6'd8,  A_SLTU  = 6'd9,  A_LB    = 6'd10, A_LH    = 6'd11,
        A_LW    = 6'd12, A_LBU   = 6'd13, A_LHU   = 6'd14, A_ADDI  = 6'd15,
        A_XORI  = 6'd16, A_ORI   = 6'd17, A_ANDI  = 6'd18, A_SLLI  = 6'd19,
        A_SRLI  = 6'd20, A_SRAI  = 6'd21, A_SLTI  = 6'd22, A_SLTIU = 6'd23,
        A_JALR  = 6'd24, A_SB    = 6'd25, A_SH    = 6'd26, A_SW    = 6'd27,
        A_BEQ   = 6'd28, A_BNE   = 6'd29, A_BLT   = 6'd30, A_BGE   = 6'd31,
        A_BLTU  = 6'd32, A_BGEU  = 6'd33, A_LUI   = 6'd34, A_AUIPC = 6'd35,
        A_JAL   = 6'd36
    } t_action;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [XLEN-1:0]  operand_a;
        logic [XLEN-1:0]  operand_b;
        logic [XLEN-1:0]  immediate;
        logic [XLEN-1:0]  inst_pc;
        logic [REG_W-1:0] dest_reg;
        logic             predicted_taken;
    } t_in_item;

    typedef struct packed {
        logic [XLEN-1:0]   result_value;
        logic [XLEN-1:0]   store_value;
        logic [REG_W-1:0]  dest_out;
        logic [XLEN-1:0]   next_pc;
        logic              redirect;
        logic              branch_taken;
        logic [SLOT_W-1:0] predictor_slot;
        logic              is_branch;
    } t_out_item;

endpackage

// File: sv/rvex_core.sv
// ----------------------------------------------------------------------------
// rvex_core
// ALU, address generation and branch resolution for one instruction.
// ----------------------------------------------------------------------------
module rvex_core import rvex_pkg::*; (
    input  t_in_item  i_item,
    output t_out_item o_item
);

    logic [XLEN-1:0]    a;
    logic [XLEN-1:0]    op2;
    logic               use_b;
    logic [SHAMT_W-1:0] shamt;
    logic [XLEN-1:0]    sum;
    logic [XLEN-1:0]    diff;
    logic [XLEN-1:0]    pc_plus4;
    logic [XLEN-1:0]    pc_plus_imm;
    logic [XLEN-1:0]    slot_full;
    logic               cmp_eq;
    logic               cmp_lt_s;
    logic               cmp_lt_u;
    logic               taken;

    assign a = i_item.operand_a;

    // register operand for R-type ops and branches, immediate otherwise
    assign use_b = (i_item.action <= A_SLTU) ||
                   ((i_item.action >= A_BEQ) && (i_item.action <= A_BGEU));
    assign op2   = use_b ? i_item.operand_b : i_item.immediate;
    assign shamt = op2[SHAMT_W-1:0];

    assign sum         = a + op2;
    assign diff        = a - op2;
    assign pc_plus4    = i_item.inst_pc + PC_STEP;
    assign pc_plus_imm = i_item.inst_pc + i_item.immediate;

    assign cmp_eq   = (a == op2);
    assign cmp_lt_s = ($signed(a) < $signed(op2));
    assign cmp_lt_u = (a < op2);

    assign slot_full = (i_item.inst_pc >> 2) & PRED_SLOT_MASK;

    always_comb begin
        o_item                = '0;
        o_item.predictor_slot = slot_full[SLOT_W-1:0];
        o_item.dest_out       = (i_item.dest_reg > NO_DEST) ? NO_DEST : i_item.dest_reg;
        taken                 = 1'b0;
        case (i_item.action)
            A_ADD, A_ADDI, A_LB, A_LH, A_LW, A_LBU, A_LHU: begin
                o_item.result_value = sum;
            end
            A_SUB: o_item.result_value = diff;
            A_XOR, A_XORI: o_item.result_value = a ^ op2;
            A_OR, A_ORI: o_item.result_value = a | op2;
            A_AND, A_ANDI: o_item.result_value = a & op2;
            A_SLL, A_SLLI: o_item.result_value = a << shamt;
            A_SRL, A_SRLI: o_item.result_value = a >> shamt;
            A_SRA, A_SRAI: o_item.result_value = XLEN'($signed(a) >>> shamt);
            A_SLT, A_SLTI: o_item.result_value = XLEN'(cmp_lt_s);
            A_SLTU, A_SLTIU: o_item.result_value = XLEN'(cmp_lt_u);
            A_JALR: begin
                o_item.result_value = pc_plus4;
                o_item.next_pc      = sum & JALR_MASK;
            end
            A_SB, A_SH, A_SW: begin
                o_item.result_value = sum;
                o_item.store_value  = i_item.operand_b;
            end
            A_BEQ, A_BNE, A_BLT, A_BGE, A_BLTU, A_BGEU: begin
                case (i_item.action)
                    A_BEQ:   taken = cmp_eq;
                    A_BNE:   taken = !cmp_eq;
                    A_BLT:   taken = cmp_lt_s;
                    A_BGE:   taken = !cmp_lt_s;
                    A_BLTU:  taken = cmp_lt_u;
                    default: taken = !cmp_lt_u;
                endcase
                o_item.is_branch    = 1'b1;
                o_item.branch_taken = taken;
                o_item.next_pc      = taken ? pc_plus_imm : pc_plus4;
                o_item.redirect     = (taken != i_item.predicted_taken);
            end
            A_LUI: o_item.result_value = i_item.immediate;
            A_AUIPC: o_item.result_value = pc_plus_imm;
            A_JAL: begin
                o_item.result_value = pc_plus4;
                o_item.next_pc      = pc_plus_imm;
            end
            default: begin
                // unknown operation: nothing written back
                o_item.dest_out = NO_DEST;
            end
        endcase
    end

endmodule

// File: sv/rv32i_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// RV32I execute stage: one item in, one item out. Each item is latched in an
// input register, resolved by the ALU and branch logic in a single pass and
// held in a result register; one item can be accepted every cycle while the
// downstream side takes items. The result register sets the pace: a new item
// is taken whenever the input register is empty or can move into the result
// register, which frees when the downstream side takes its item. Branch
// mispredictions raise redirect with the corrected address; jumps give their
// target on next_pc without redirect.
// ----------------------------------------------------------------------------
`include "rv32i_execute_unit_defines.svh"

module rv32i_execute_unit import rvex_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_in_v;
    t_in_item  r_in;
    logic      r_out_v;
    t_out_item r_out;
    t_out_item n_out;
    logic      s1_adv;
    logic      in_take;

    assign s1_adv     = !r_out_v || i_out_ready;
    assign o_in_ready = !r_in_v || s1_adv;
    assign in_take    = i_in_valid && o_in_ready;

    rvex_core u_core (
        .i_item (r_in),
        .o_item (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_take) begin
            r_in_v <= 1'b1;
        end else if (s1_adv) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_in_v) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    // both registers full and downstream stalled: no room for another item
    `RVEX_ASSERT_SAME(a_full_stall, i_clk, i_rst_n, r_in_v && r_out_v && !i_out_ready, !o_in_ready)
    `RVEX_ASSERT_NEXT(a_take_lands, i_clk, i_rst_n, in_take, r_in_v)
    `RVEX_ASSERT_SAME(a_redir_br, i_clk, i_rst_n, r_out_v && r_out.redirect, r_out.is_branch)
    `RVEX_ASSERT_SAME(a_dest_rng, i_clk, i_rst_n, r_out_v, r_out.dest_out <= NO_DEST)

endmodule
